FILE: hdl/lane_choice_cost_argmin_macros.svh
// Assertion macros used by the checker of the lane choice block.
// Both expect clk and arst_n in scope.
`ifndef LANE_CHOICE_COST_ARGMIN_MACROS_SVH
`define LANE_CHOICE_COST_ARGMIN_MACROS_SVH

// same-cycle implication
`define LCCA_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LCCA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/lcca_pkg.sv
package lcca_pkg;

	localparam int COST_W = 24;
	localparam logic [COST_W-1:0] COST_MAX = 24'hFF_FFFF;

	typedef enum logic [2:0] {
		CMD_BEGIN   = 3'd0,
		CMD_PROFILE = 3'd1,
		CMD_FLOW    = 3'd2,
		CMD_RISK    = 3'd3,
		CMD_DECIDE  = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD_WR,
		ST_RISK_WR,
		ST_DEC_SCAN,
		ST_DEC_DRAIN,
		ST_DEC_FIN,
		ST_EMIT
	} lcca_state_t;

	localparam logic CFG_LANES_IN_USE = 1'b0;
	localparam logic CFG_VALID_MASK   = 1'b1;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic              prof;
		logic              flow;
	} entry_t;

	// one lane evaluation travelling down the decide pipeline
	typedef struct packed {
		logic       live;
		logic       seed;
		logic [3:0] lane;
	} eval_tag_t;

	function automatic logic [COST_W-1:0] sat_add(input logic [COST_W-1:0] a,
			input logic [COST_W-1:0] b);
		logic [COST_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COST_W] ? COST_MAX : s[COST_W-1:0];
	endfunction

	function automatic logic [3:0] lane_dist(input logic [3:0] a, input logic [3:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

FILE: hdl/lcca_ram.sv
module lcca_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/lcca_cost.sv
module lcca_cost #(
	parameter int SCORE_FRAC_BITS = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lcca_pkg::eval_tag_t tag_s1,
	input  lcca_pkg::entry_t   view,
	input  logic [3:0]         goal,
	output lcca_pkg::eval_tag_t tag_s2,
	output logic [lcca_pkg::COST_W-1:0] fc_s2
);
	import lcca_pkg::*;

	localparam int KW = SCORE_FRAC_BITS + 2;
	localparam logic [KW-1:0] K_NOPROF = KW'(((30 << SCORE_FRAC_BITS) + 50) / 100);
	localparam logic [KW-1:0] K_NOFLOW = KW'(((20 << SCORE_FRAC_BITS) + 50) / 100);
	localparam logic [KW-1:0] K_STEP   = KW'(((8 << SCORE_FRAC_BITS) + 50) / 100);

	logic [COST_W-1:0] c_prof;
	logic [COST_W-1:0] c_flow;
	logic [COST_W-1:0] step_cost;
	logic [COST_W-1:0] full;

	// missing-data penalties, then distance to the goal lane
	assign c_prof    = view.prof ? view.cost : sat_add(view.cost, COST_W'(K_NOPROF));
	assign c_flow    = view.flow ? c_prof : sat_add(c_prof, COST_W'(K_NOFLOW));
	assign step_cost = COST_W'(lane_dist(tag_s1.lane, goal)) * COST_W'(K_STEP);
	assign full      = sat_add(c_flow, step_cost);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		fc_s2 <= full;
	end

endmodule

FILE: hdl/lane_choice_cost_argmin.sv
// Lane choice by least cost. Per-lane cost and seen flags live in one
// synchronous RAM with one read and one write port; valid bits in flops make
// a begin clear the table at once. Begin is taken in the idle state; profile,
// flow and risk go through a write-back state, and risk through a second one
// when its target lane differs from its lane (the read-modify-write of each
// lane goes through the RAM port in turn). Decide walks the RAM one lane per
// cycle over n = min(lanes_in_use, MAX_LANES, 16) lanes, then one result
// word per cycle while out_stall is low for each path entry, from the own
// lane to the chosen lane. No item is taken while a decide runs; the last
// result word may wait in the output register while the next item is taken.
module lane_choice_cost_argmin #(
	parameter int MAX_LANES       = 16,
	parameter int SCORE_FRAC_BITS = 12
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [3:0]  item_lane,
	input  logic [3:0]  target_lane,
	input  logic [12:0] score,
	input  logic        blocked,
	input  logic [3:0]  own_lane,
	input  logic [3:0]  goal_lane,
	input  logic [3:0]  scene_lane,
	input  logic [12:0] scene_lane_risk,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  chosen_lane,
	output logic        route_aligned,
	output logic [12:0] confidence,
	output logic [3:0]  sequence_lane,
	output logic        last
);
	import lcca_pkg::*;

	localparam int AW = $clog2(MAX_LANES);
	localparam int KW = SCORE_FRAC_BITS + 2;
	localparam int PW = 13 + KW;
	localparam logic [KW-1:0] K_FLOW = KW'(((35 << SCORE_FRAC_BITS) + 50) / 100);
	localparam logic [KW-1:0] K_RISK = KW'(((18 << SCORE_FRAC_BITS) + 50) / 100);
	localparam logic [KW-1:0] K_STEP = KW'(((8 << SCORE_FRAC_BITS) + 50) / 100);
	localparam logic [KW-1:0] K_BASE = KW'(((125 << SCORE_FRAC_BITS) + 50) / 100);
	localparam logic [KW-1:0] Q_ONE  = KW'(1 << SCORE_FRAC_BITS);
	localparam logic [PW-1:0] HALF   = PW'(1 << (SCORE_FRAC_BITS - 1));
	localparam logic [4:0] SCAN_CAP  = 5'((MAX_LANES < 16) ? MAX_LANES : 16);

	function automatic logic lane_ok(input logic [3:0] l);
		return {28'd0, l} < 32'(MAX_LANES);
	endfunction

	lcca_state_t state_q, state_d;

	logic [4:0]           lanes_q;
	logic [15:0]          mask_q;
	logic [MAX_LANES-1:0] valid_q;
	logic [3:0]           held_own_q;
	logic [3:0]           held_goal_q;

	cmd_t              cmd_q;
	logic [3:0]        lane_q;
	logic [3:0]        target_q;
	logic [COST_W-1:0] amount_q;

	logic [4:0]        slot_q;
	logic [4:0]        scan_n_q;
	eval_tag_t         tag_s1;
	eval_tag_t         tag_s2;
	logic [COST_W-1:0] fc_s2;
	logic [3:0]        best_q;
	logic [COST_W-1:0] best_cost_q;
	logic              aligned_q;
	logic [12:0]       conf_q;
	logic [3:0]        cur_q;

	logic        out_valid_q;
	logic [3:0]  chosen_q;
	logic        aligned_out_q;
	logic [12:0] conf_out_q;
	logic [3:0]  seq_q;
	logic        last_q;

	logic              idle;
	logic              in_acc;
	logic              issue;
	logic              emit_load;
	logic [3:0]        scan_lane;
	logic [3:0]        view_lane;
	logic              view_ok;
	entry_t            ram_rdata;
	entry_t            view;
	logic [COST_W-1:0] upd_cost;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [AW-1:0]     ram_raddr;
	entry_t            ram_wdata;

	logic [KW-1:0]     k_sel;
	logic [PW-1:0]     prod;
	logic [COST_W-1:0] scaled;
	logic [COST_W-1:0] amount_d;

	logic [COST_W-1:0] conf_diff;
	logic [COST_W-1:0] conf_clamp;
	logic              better;

	assign idle     = (state_q == ST_IDLE);
	assign in_stall = !idle;
	assign in_acc   = in_valid && idle;

	// scaled load amount, formed while the RAM read is in flight
	assign k_sel  = (command == CMD_FLOW) ? K_FLOW : K_RISK;
	assign prod   = PW'(score) * PW'(k_sel) + HALF;
	assign scaled = COST_W'(prod >> SCORE_FRAC_BITS);

	always_comb begin
		case (command)
			CMD_PROFILE: amount_d = COST_W'(score);
			CMD_FLOW:    amount_d = scaled + (blocked ? COST_W'(K_FLOW) : '0);
			default:     amount_d = scaled;
		endcase
	end

	assign scan_lane = (slot_q == 5'd0) ? held_own_q : 4'(slot_q - 5'd1);

	always_comb begin
		case (state_q)
			ST_LOAD_WR: view_lane = lane_q;
			ST_RISK_WR: view_lane = target_q;
			default:    view_lane = tag_s1.lane;
		endcase
	end

	// entries outside the table or not written since begin read as zero
	assign view_ok  = lane_ok(view_lane) && valid_q[AW'(view_lane)];
	assign view     = view_ok ? ram_rdata : '0;
	assign upd_cost = sat_add(view.cost, amount_q);

	lcca_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(MAX_LANES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	lcca_cost #(
		.SCORE_FRAC_BITS(SCORE_FRAC_BITS)
	) u_cost (
		.clk   (clk),
		.arst_n(arst_n),
		.tag_s1(tag_s1),
		.view  (view),
		.goal  (held_goal_q),
		.tag_s2(tag_s2),
		.fc_s2 (fc_s2)
	);

	assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					case (command)
						CMD_PROFILE, CMD_FLOW, CMD_RISK: state_d = ST_LOAD_WR;
						CMD_DECIDE:                      state_d = ST_DEC_SCAN;
						default:                         state_d = ST_IDLE;
					endcase
				end
			end
			ST_LOAD_WR: begin
				if (cmd_q == CMD_RISK && target_q != lane_q) begin
					state_d = ST_RISK_WR;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_RISK_WR:  state_d = ST_IDLE;
			ST_DEC_SCAN: begin
				if (slot_q == scan_n_q) begin
					state_d = ST_DEC_DRAIN;
				end
			end
			ST_DEC_DRAIN: begin
				if (!tag_s1.live && !tag_s2.live) begin
					state_d = ST_DEC_FIN;
				end
			end
			ST_DEC_FIN: state_d = ST_EMIT;
			ST_EMIT: begin
				if (emit_load && cur_q == best_q) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ram_we         = 1'b0;
		ram_waddr      = AW'(lane_q);
		ram_raddr      = AW'(item_lane);
		ram_wdata      = view;
		ram_wdata.cost = upd_cost;
		issue          = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && command == CMD_BEGIN) begin
					ram_we         = lane_ok(scene_lane);
					ram_waddr      = AW'(scene_lane);
					ram_wdata.cost = COST_W'(scene_lane_risk);
					ram_wdata.prof = 1'b0;
					ram_wdata.flow = 1'b0;
				end
			end
			ST_LOAD_WR: begin
				// read the risk target while the first lane is written back
				ram_raddr = AW'(target_q);
				case (cmd_q)
					CMD_PROFILE: begin
						ram_we         = lane_ok(lane_q) && !view.prof;
						ram_wdata.prof = 1'b1;
					end
					CMD_FLOW: begin
						ram_we         = lane_ok(lane_q) && !view.flow;
						ram_wdata.flow = 1'b1;
					end
					CMD_RISK: ram_we = lane_ok(lane_q);
					default:  ram_we = 1'b0;
				endcase
			end
			ST_RISK_WR: begin
				ram_waddr = AW'(target_q);
				ram_we    = lane_ok(target_q);
			end
			ST_DEC_SCAN: begin
				ram_raddr = AW'(scan_lane);
				issue     = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lanes_q <= 5'd16;
			mask_q  <= 16'hFFFF;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_LANES_IN_USE: lanes_q <= cfg_data[4:0];
				CFG_VALID_MASK:   mask_q  <= cfg_data;
				default:          lanes_q <= lanes_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			held_own_q  <= '0;
			held_goal_q <= '0;
			slot_q      <= '0;
			tag_s1      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc && command == CMD_BEGIN) begin
				valid_q     <= '0;
				held_own_q  <= own_lane;
				held_goal_q <= goal_lane;
			end
			if (ram_we) begin
				valid_q[ram_waddr] <= 1'b1;
			end
			if (in_acc && command == CMD_DECIDE) begin
				slot_q <= '0;
			end else if (issue) begin
				slot_q <= slot_q + 5'd1;
			end
			tag_s1.live <= issue;
			tag_s1.seed <= (slot_q == 5'd0);
			tag_s1.lane <= scan_lane;
			if (emit_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a scanned lane must beat the best so far by the step margin
	assign better = ({1'b0, fc_s2} + (COST_W + 1)'(K_STEP)) < {1'b0, best_cost_q};

	assign conf_diff  = (best_cost_q >= COST_W'(K_BASE)) ? '0 : COST_W'(K_BASE) - best_cost_q;
	assign conf_clamp = (conf_diff > COST_W'(Q_ONE)) ? COST_W'(Q_ONE) : conf_diff;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q    <= cmd_t'(command);
			lane_q   <= item_lane;
			target_q <= target_lane;
			amount_q <= amount_d;
			scan_n_q <= (lanes_q > SCAN_CAP) ? SCAN_CAP : lanes_q;
		end
		if (tag_s2.live) begin
			if (tag_s2.seed || (mask_q[tag_s2.lane] && better)) begin
				best_q      <= tag_s2.lane;
				best_cost_q <= fc_s2;
			end
		end
		if (state_q == ST_DEC_FIN) begin
			aligned_q <= (best_q == held_goal_q) ||
				(lane_dist(best_q, held_goal_q) <= lane_dist(held_own_q, held_goal_q));
			conf_q    <= conf_clamp[12:0];
			cur_q     <= held_own_q;
		end
		if (emit_load) begin
			chosen_q      <= best_q;
			aligned_out_q <= aligned_q;
			conf_out_q    <= conf_q;
			seq_q         <= cur_q;
			last_q        <= (cur_q == best_q);
			// advance one lane toward the chosen lane
			if (best_q > cur_q) begin
				cur_q <= cur_q + 4'd1;
			end else if (best_q < cur_q) begin
				cur_q <= cur_q - 4'd1;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign chosen_lane   = chosen_q;
	assign route_aligned = aligned_out_q;
	assign confidence    = conf_out_q;
	assign sequence_lane = seq_q;
	assign last          = last_q;

endmodule

FILE: hdl/lcca_checker.sv
`include "lane_choice_cost_argmin_macros.svh"

module lcca_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  chosen_lane,
	input logic        route_aligned,
	input logic [12:0] confidence,
	input logic [3:0]  sequence_lane,
	input logic        last
);

	`LCCA_ASSERT_NEXT(a_hold_word, out_valid && out_stall, out_valid && $stable(chosen_lane) && $stable(sequence_lane) && $stable(confidence) && $stable(last), "stalled result word changed")

	`LCCA_ASSERT_NEXT(a_path_step, out_valid && !out_stall && !last, out_valid && chosen_lane == $past(chosen_lane) && route_aligned == $past(route_aligned) && confidence == $past(confidence) && (sequence_lane == $past(sequence_lane) + 4'd1 || sequence_lane == $past(sequence_lane) - 4'd1), "path word does not follow by one lane")

	`LCCA_ASSERT_NOW(a_busy_in_path, out_valid && !last, in_stall, "input taken in the middle of a path")

	`LCCA_ASSERT_NOW(a_path_end, out_valid && last, sequence_lane == chosen_lane, "path does not end at the chosen lane")

endmodule

bind lane_choice_cost_argmin lcca_checker u_lcca_checker (.*);
